// ===== rtl/image_orientation_rotator_core_assert.svh =====
// ---------------------------------------------------------------------------
// Image orientation rotator assertion macros
// Short forms for the clocked checks of the rotator core.
// ---------------------------------------------------------------------------
`ifndef IMAGE_ORIENTATION_ROTATOR_CORE_ASSERT_SVH
`define IMAGE_ORIENTATION_ROTATOR_CORE_ASSERT_SVH

// Same-cycle implication, reset masked.
`define IOR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rotator check failed");

// Next-cycle implication, reset masked.
`define IOR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rotator check failed");

`endif

// ===== rtl/ior_pkg.sv =====
// ---------------------------------------------------------------------------
// Image orientation rotator package
// Transfer types, register indexes and codes shared by the rotator.
// ---------------------------------------------------------------------------
`default_nettype none

package ior_pkg;

  localparam int DIM_W  = 9;           // width of a dimension or position
  localparam int PROD_W = 2 * DIM_W;   // width of a dimension product
  localparam int PIX_W  = 24;          // pixel field width

  // Configuration register indexes
  localparam logic [1:0] REG_ORIENT = 2'd0;
  localparam logic [1:0] REG_FORMAT = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // Item functions
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // Pixel formats
  localparam logic FMT_8BIT  = 1'b0;
  localparam logic FMT_24BIT = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_LOADED = 2'd1;
  localparam logic [1:0] STAT_FULL       = 2'd2;

  // Orientation codes; bit 2 set means rows and columns swap
  localparam logic [2:0] MODE_PLAIN     = 3'd0;
  localparam logic [2:0] MODE_MIRROR    = 3'd1;
  localparam logic [2:0] MODE_HALF_TURN = 3'd2;
  localparam logic [2:0] MODE_FLIP      = 3'd3;
  localparam logic [2:0] MODE_DIAG      = 3'd4;
  localparam logic [2:0] MODE_CW        = 3'd5;
  localparam logic [2:0] MODE_ANTIDIAG  = 3'd6;
  localparam logic [2:0] MODE_CCW       = 3'd7;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel_in;
  } ior_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic [1:0]       status;
  } ior_out_t;

endpackage

`default_nettype wire

// ===== rtl/image_orientation_rotator_core.sv =====
// ---------------------------------------------------------------------------
// Image orientation rotator core
// Reorients a frame to any of the eight EXIF orientations via a frame store.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: an item transfers at a rising edge with start high and busy
//   low. busy stays low: every cycle can carry one item. A load item (func 0)
//   writes in_data.pixel_in into the frame store at its reoriented address; a
//   fetch item (func 1) reads the next output pixel in raster order.
//   Result channel: exactly one result per item, on out_data with out_valid
//   high for one cycle, in the cycle after the input transfer. The receiver
//   cannot stall, so nothing is ever held back.
//   Throughput: one item per clock. Results are registered, as is the read of
//   the single-port frame store (one store access per item).
//   Config port: cfg_we/cfg_index/cfg_data write orient_mode, pixel_format,
//   image_width and image_height. Any write restarts the frame (positions,
//   full flag, read index cleared); store contents are kept. Write only when
//   idle.
//   Out-of-order items (fetch before a full frame, load into a full frame)
//   return status codes and change nothing.
//   Reset: registers return to mode normal, 24-bit pixels, 256x256 and an
//   empty frame. The store is not cleared; it is only read after a complete
//   load has written every output address.
// ---------------------------------------------------------------------------
`default_nettype none

module image_orientation_rotator_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              start,
  output logic                   busy,
  input  wire ior_pkg::ior_in_t  in_data,
  // result channel
  output logic                   out_valid,
  output ior_pkg::ior_out_t      out_data,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ior_pkg::DIM_W-1:0] cfg_data
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_TOP = (1 << ior_pkg::DIM_W) - 1;
  localparam int WCAP    = (MAX_WIDTH  > DIM_TOP) ? DIM_TOP : MAX_WIDTH;
  localparam int HCAP    = (MAX_HEIGHT > DIM_TOP) ? DIM_TOP : MAX_HEIGHT;
  localparam int DW      = ior_pkg::DIM_W;
  localparam int PW      = ior_pkg::PROD_W;

  // ---- configuration registers ----
  logic [2:0]    orient_r;
  logic          format_r;
  logic [DW-1:0] width_r;
  logic [DW-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= ior_pkg::MODE_PLAIN;
      format_r <= ior_pkg::FMT_24BIT;
      width_r  <= DW'(256);
      height_r <= DW'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ior_pkg::REG_ORIENT: orient_r <= cfg_data[2:0];
        ior_pkg::REG_FORMAT: format_r <= cfg_data[0];
        ior_pkg::REG_WIDTH:  width_r  <= cfg_data;
        ior_pkg::REG_HEIGHT: height_r <= cfg_data;
      endcase
    end
  end

  // Effective dimensions: zero reads as one, clamp at the store maximum.
  logic [DW-1:0] w_eff, h_eff, ow, oh;
  logic          swap;

  always_comb begin
    if (width_r == '0)              w_eff = DW'(1);
    else if (width_r > DW'(WCAP))   w_eff = DW'(WCAP);
    else                            w_eff = width_r;
    if (height_r == '0)             h_eff = DW'(1);
    else if (height_r > DW'(HCAP))  h_eff = DW'(HCAP);
    else                            h_eff = height_r;
  end

  assign swap = orient_r[2];
  assign ow   = swap ? h_eff : w_eff;
  assign oh   = swap ? w_eff : h_eff;

  // ---- frame control state ----
  logic [DW-1:0] load_row_r, load_row_nxt;
  logic [DW-1:0] load_col_r, load_col_nxt;
  logic          full_r, full_nxt;
  logic [AW-1:0] read_index_r, read_index_nxt;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Source position, bounded inside the frame.
  logic [DW-1:0] r, c, dr, dc;
  logic [PW-1:0] addr_sum, total;
  logic [AW-1:0] waddr;

  always_comb begin
    r = (load_row_r < h_eff) ? load_row_r : h_eff - DW'(1);
    c = (load_col_r < w_eff) ? load_col_r : w_eff - DW'(1);
    unique case (orient_r)
      ior_pkg::MODE_PLAIN:     begin dr = r;                  dc = c; end
      ior_pkg::MODE_MIRROR:    begin dr = r;                  dc = w_eff - DW'(1) - c; end
      ior_pkg::MODE_HALF_TURN: begin dr = h_eff - DW'(1) - r; dc = w_eff - DW'(1) - c; end
      ior_pkg::MODE_FLIP:      begin dr = h_eff - DW'(1) - r; dc = c; end
      ior_pkg::MODE_DIAG:      begin dr = c;                  dc = r; end
      ior_pkg::MODE_CW:        begin dr = c;                  dc = h_eff - DW'(1) - r; end
      ior_pkg::MODE_ANTIDIAG:  begin dr = w_eff - DW'(1) - c; dc = h_eff - DW'(1) - r; end
      ior_pkg::MODE_CCW:       begin dr = w_eff - DW'(1) - c; dc = r; end
    endcase
    // destination row times destination row width, plus column
    addr_sum = PW'(dr) * PW'(ow) + PW'(dc);
    waddr    = AW'(addr_sum);
    total    = PW'(w_eff) * PW'(h_eff);
  end

  // Store write data: 8-bit format keeps the low byte.
  logic [ior_pkg::PIX_W-1:0] load_pix;
  assign load_pix = (format_r == ior_pkg::FMT_8BIT)
                    ? {{(ior_pkg::PIX_W-8){1'b0}}, in_data.pixel_in[7:0]}
                    : in_data.pixel_in;

  logic       wr_en, rd_en, last_nxt;
  logic [1:0] status_nxt;

  always_comb begin
    load_row_nxt   = load_row_r;
    load_col_nxt   = load_col_r;
    full_nxt       = full_r;
    read_index_nxt = read_index_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    last_nxt       = 1'b0;
    status_nxt     = ior_pkg::STAT_OK;
    if (cfg_we) begin
      // any register write restarts the frame
      load_row_nxt   = '0;
      load_col_nxt   = '0;
      full_nxt       = 1'b0;
      read_index_nxt = '0;
    end else if (accept) begin
      if (in_data.func == ior_pkg::FUNC_LOAD) begin
        if (full_r) begin
          status_nxt = ior_pkg::STAT_FULL;
        end else begin
          wr_en = 1'b1;
          if ((DW+1)'(c) + (DW+1)'(1) >= (DW+1)'(w_eff)) begin
            load_col_nxt = '0;
            if ((DW+1)'(r) + (DW+1)'(1) >= (DW+1)'(h_eff)) begin
              load_row_nxt   = '0;
              full_nxt       = 1'b1;
              read_index_nxt = '0;
            end else begin
              load_row_nxt = r + DW'(1);
            end
          end else begin
            load_col_nxt = c + DW'(1);
          end
        end
      end else begin
        if (!full_r) begin
          status_nxt = ior_pkg::STAT_NOT_LOADED;
        end else begin
          rd_en = 1'b1;
          if ((PW+1)'(read_index_r) + (PW+1)'(1) >= (PW+1)'(total)) begin
            // final pixel: frame done, ready for the next load
            last_nxt       = 1'b1;
            load_row_nxt   = '0;
            load_col_nxt   = '0;
            full_nxt       = 1'b0;
            read_index_nxt = '0;
          end else begin
            read_index_nxt = read_index_r + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r   <= '0;
      load_col_r   <= '0;
      full_r       <= 1'b0;
      read_index_r <= '0;
    end else begin
      load_row_r   <= load_row_nxt;
      load_col_r   <= load_col_nxt;
      full_r       <= full_nxt;
      read_index_r <= read_index_nxt;
    end
  end

  // ---- frame store: one port, registered read ----
  logic [PIXEL_BITS-1:0] frame_mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[waddr] <= PIXEL_BITS'(load_pix);
    end
    if (rd_en) begin
      rd_data_r <= frame_mem[read_index_r];
    end
  end

  // ---- result register ----
  logic          out_valid_r;
  logic          fetch_ok_r;
  logic          last_r;
  logic [1:0]    status_r;
  logic [DW-1:0] ow_r, oh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    fetch_ok_r <= rd_en;
    last_r     <= last_nxt;
    status_r   <= status_nxt;
    ow_r       <= ow;
    oh_r       <= oh;
  end

  assign out_valid           = out_valid_r;
  assign out_data.pixel_out  = fetch_ok_r ? ior_pkg::PIX_W'(rd_data_r) : '0;
  assign out_data.last_pixel = last_r;
  assign out_data.out_width  = ow_r;
  assign out_data.out_height = oh_r;
  assign out_data.status     = status_r;

  // ---- checks ----
`include "image_orientation_rotator_core_assert.svh"

  `IOR_ASSERT_NEXT(a_result_per_item, accept, out_valid)
  `IOR_ASSERT_NEXT(a_no_spurious_result, !accept, !out_valid)
  `IOR_ASSERT_NOW(a_full_positions_clear, full_r, (load_row_r == '0) && (load_col_r == '0))
  `IOR_ASSERT_NOW(a_read_idle_when_empty, !full_r, read_index_r == '0)
  `IOR_ASSERT_NOW(a_last_is_ok, out_valid && out_data.last_pixel,
                  out_data.status == ior_pkg::STAT_OK)

endmodule

`default_nettype wire

// ===== verif/tb_image_orientation_rotator_core.sv =====
// ---------------------------------------------------------------------------
// Image orientation rotator core testbench
// Loads frames into the rotator under every orientation, pixel format and a
// spread of sizes, then fetches them back. A cycle-level predictor in the
// testbench works out each result, and every result is checked field by field.
// ---------------------------------------------------------------------------
module tb_image_orientation_rotator_core;

  localparam int STORE_DEPTH     = 65536;  // 256 x 256 frame store
  localparam int MAX_DIM         = 256;    // both dimension limits
  localparam int IDLE_PCT        = 17;     // sender idle chance per transfer
  localparam int MAX_PRINTS      = 100;    // cap on printed mismatch lines
  localparam int RANDOM_OK_ITEMS = 150;    // accepted loads/fetches in random part
  localparam int DRAIN_CYCLES    = 4;      // drain margin after the last result

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  ior_pkg::ior_in_t          in_data;
  logic                      out_valid;
  ior_pkg::ior_out_t         out_data;
  logic                      cfg_we;
  logic [1:0]                cfg_index;
  logic [ior_pkg::DIM_W-1:0] cfg_data;

  // Predictor copy of the block's registers and frame state
  logic [2:0]                pred_orient;
  logic                      pred_format;
  logic [ior_pkg::DIM_W-1:0] pred_width_reg;
  logic [ior_pkg::DIM_W-1:0] pred_height_reg;
  logic [ior_pkg::PIX_W-1:0] pred_frame [STORE_DEPTH];
  int unsigned               pred_load_row;
  int unsigned               pred_load_col;
  int unsigned               pred_read_idx;
  bit                        pred_full;

  ior_pkg::ior_out_t pending_results[$];  // predicted results, oldest first
  ior_pkg::ior_out_t result_due;
  int                mismatches;
  int unsigned       good_transfers;      // transfers predicted with status ok
  bit                idle_enable;

  image_orientation_rotator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #1_000_000;
    $display("image_orientation_rotator_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Out-of-range dimensions: zero acts as one, anything above the max as the max.
  function automatic int unsigned clamp_dim(logic [ior_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void restart_frame();
    pred_load_row = 0;
    pred_load_col = 0;
    pred_full     = 1'b0;
    pred_read_idx = 0;
  endfunction

  // Every register write restarts the frame; store contents survive.
  function automatic void apply_reg_write(logic [1:0] idx,
                                          logic [ior_pkg::DIM_W-1:0] val);
    case (idx)
      ior_pkg::REG_ORIENT: pred_orient     = val[2:0];
      ior_pkg::REG_FORMAT: pred_format     = val[0];
      ior_pkg::REG_WIDTH:  pred_width_reg  = val;
      ior_pkg::REG_HEIGHT: pred_height_reg = val;
    endcase
    restart_frame();
  endfunction

  // Reoriented store address of source pixel (r, c) in a w x h image.
  // Swapping modes use the source height as destination row width.
  function automatic int unsigned rotated_addr(int unsigned r, int unsigned c,
                                               int unsigned w, int unsigned h);
    int unsigned dr;
    int unsigned dc;
    case (pred_orient)
      ior_pkg::MODE_MIRROR:    begin dr = r;         dc = w - 1 - c; end
      ior_pkg::MODE_HALF_TURN: begin dr = h - 1 - r; dc = w - 1 - c; end
      ior_pkg::MODE_FLIP:      begin dr = h - 1 - r; dc = c;         end
      ior_pkg::MODE_DIAG:      begin dr = c;         dc = r;         end
      ior_pkg::MODE_CW:        begin dr = c;         dc = h - 1 - r; end
      ior_pkg::MODE_ANTIDIAG:  begin dr = w - 1 - c; dc = h - 1 - r; end
      ior_pkg::MODE_CCW:       begin dr = w - 1 - c; dc = r;         end
      default:                 begin dr = r;         dc = c;         end
    endcase
    return (dr * (pred_orient[2] ? h : w) + dc) % STORE_DEPTH;
  endfunction

  // Result of one accepted item; advances the predictor state.
  function automatic ior_pkg::ior_out_t rotate_step(ior_pkg::ior_in_t item);
    ior_pkg::ior_out_t         res;
    int unsigned               w;
    int unsigned               h;
    int unsigned               r;
    int unsigned               c;
    int unsigned               idx;
    logic [ior_pkg::PIX_W-1:0] pix;
    w = clamp_dim(pred_width_reg);
    h = clamp_dim(pred_height_reg);
    res = '0;
    res.out_width  = ior_pkg::DIM_W'(pred_orient[2] ? h : w);
    res.out_height = ior_pkg::DIM_W'(pred_orient[2] ? w : h);
    if (item.func == ior_pkg::FUNC_LOAD) begin
      if (pred_full) begin
        res.status = ior_pkg::STAT_FULL;
      end else begin
        pix = item.pixel_in;
        if (pred_format == ior_pkg::FMT_8BIT) pix[ior_pkg::PIX_W-1:8] = '0;
        r = (pred_load_row < h) ? pred_load_row : h - 1;
        c = (pred_load_col < w) ? pred_load_col : w - 1;
        pred_frame[rotated_addr(r, c, w, h)] = pix;
        if (c + 1 >= w) begin
          pred_load_col = 0;
          if (r + 1 >= h) begin
            pred_load_row = 0;
            pred_full     = 1'b1;
            pred_read_idx = 0;
          end else begin
            pred_load_row = r + 1;
          end
        end else begin
          pred_load_col = c + 1;
        end
      end
    end else if (!pred_full) begin
      res.status = ior_pkg::STAT_NOT_LOADED;
    end else begin
      idx = pred_read_idx % STORE_DEPTH;
      res.pixel_out = pred_frame[idx];
      if (idx + 1 >= w * h) begin
        res.last_pixel = 1'b1;
        restart_frame();
      end else begin
        pred_read_idx = idx + 1;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One input transfer. Optional idle cycles first, with junk on in_data to
  // show that nothing is taken while start is low. Returns at the accepting
  // edge without touching start, so back-to-back items keep it high.
  task automatic send_item(input logic func, input logic [ior_pkg::PIX_W-1:0] pixel);
    ior_pkg::ior_in_t item;
    ior_pkg::ior_in_t junk;
    bit               taken;
    item.func     = func;
    item.pixel_in = pixel;
    if (idle_enable) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        junk.func     = 1'($urandom_range(1));
        junk.pixel_in = ior_pkg::PIX_W'($urandom);
        start   <= 1'b0;
        in_data <= junk;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_data <= item;
    // busy is sampled mid-cycle, where it holds what the next edge sees
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    result_due = rotate_step(item);
    if (result_due.status == ior_pkg::STAT_OK) good_transfers++;
    pending_results.push_back(result_due);
  endtask

  // Drop start and let every predicted result arrive.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ior_pkg::DIM_W'(val);
    @(posedge clk);
    apply_reg_write(idx, ior_pkg::DIM_W'(val));
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [2:0] orient, input logic fmt,
                           input int unsigned w, input int unsigned h);
    wait_idle();
    write_reg(ior_pkg::REG_ORIENT, orient);
    write_reg(ior_pkg::REG_FORMAT, fmt);
    write_reg(ior_pkg::REG_WIDTH, w);
    write_reg(ior_pkg::REG_HEIGHT, h);
  endtask

  // Load n random pixels, then fetch n. noise_pct mixes in out-of-order items;
  // with may_abort the frame can stop early (caller restarts it by config).
  task automatic run_frame(input int unsigned n, input int noise_pct,
                           input bit may_abort, output bit completed);
    int unsigned stop_at;
    int unsigned i;
    stop_at = 2 * n;
    if (may_abort && $urandom_range(99) < 8) stop_at = $urandom_range(2 * n - 1);
    for (i = 0; i < stop_at; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_item((i < n) ? ior_pkg::FUNC_FETCH : ior_pkg::FUNC_LOAD,
                  ior_pkg::PIX_W'($urandom));
      send_item((i < n) ? ior_pkg::FUNC_LOAD : ior_pkg::FUNC_FETCH,
                ior_pkg::PIX_W'($urandom));
    end
    completed = (stop_at == 2 * n);
  endtask

  // ---------------------------------------------------------------------------
  // Checking: the receiver cannot stall, so each strobe is one result transfer.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  ior_pkg::ior_out_t result_want;

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transfer pending, status", out_data.status, 0);
      end else begin
        result_want = pending_results.pop_front();
        if (out_data.pixel_out !== result_want.pixel_out)
          report_mismatch("pixel_out", out_data.pixel_out, result_want.pixel_out);
        if (out_data.last_pixel !== result_want.last_pixel)
          report_mismatch("last_pixel", out_data.last_pixel, result_want.last_pixel);
        if (out_data.out_width !== result_want.out_width)
          report_mismatch("out_width", out_data.out_width, result_want.out_width);
        if (out_data.out_height !== result_want.out_height)
          report_mismatch("out_height", out_data.out_height, result_want.out_height);
        if (out_data.status !== result_want.status)
          report_mismatch("status", out_data.status, result_want.status);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: 256x256, normal, 24-bit, empty frame.
  task automatic test_reset_values();
    send_item(ior_pkg::FUNC_FETCH, '0);           // nothing loaded yet
    send_item(ior_pkg::FUNC_LOAD, 24'hFFFFFF);    // first pixel of a 256x256 frame
  endtask

  task automatic test_special_cases();
    bit done;
    // zero dimensions act as 1x1; 8-bit format keeps only the low byte
    set_frame(ior_pkg::MODE_CCW, ior_pkg::FMT_8BIT, 0, 0);
    send_item(ior_pkg::FUNC_LOAD, 24'hFFFFFF);
    send_item(ior_pkg::FUNC_LOAD, 24'h123456);    // frame full: ignored
    send_item(ior_pkg::FUNC_FETCH, '0);           // last pixel, frame restarts
    send_item(ior_pkg::FUNC_FETCH, '0);           // nothing loaded again
    // small non-square frame with extreme pixel values
    set_frame(ior_pkg::MODE_CW, ior_pkg::FMT_24BIT, 3, 2);
    send_item(ior_pkg::FUNC_LOAD, 24'h000000);
    send_item(ior_pkg::FUNC_LOAD, 24'hFFFFFF);
    send_item(ior_pkg::FUNC_LOAD, 24'hA5A5A5);
    send_item(ior_pkg::FUNC_LOAD, 24'h5A5A5A);
    send_item(ior_pkg::FUNC_LOAD, 24'h800001);
    send_item(ior_pkg::FUNC_LOAD, 24'h7FFFFE);
    repeat (6) send_item(ior_pkg::FUNC_FETCH, 24'hFFFFFF);
    // a register write mid-load restarts the frame
    set_frame(ior_pkg::MODE_MIRROR, ior_pkg::FMT_24BIT, 2, 2);
    send_item(ior_pkg::FUNC_LOAD, 24'h111111);
    send_item(ior_pkg::FUNC_LOAD, 24'h222222);
    wait_idle();
    write_reg(ior_pkg::REG_FORMAT, ior_pkg::FMT_24BIT);
    run_frame(4, 0, 1'b0, done);
    // oversized dimensions clamp to the maximum
    set_frame(ior_pkg::MODE_DIAG, ior_pkg::FMT_24BIT, 511, 300);
    send_item(ior_pkg::FUNC_FETCH, '0);
  endtask

  // Every orientation on a non-square frame, so swapped axes show.
  task automatic test_each_orientation();
    int  mode;
    bit  done;
    for (mode = 0; mode < 8; mode++) begin
      set_frame(3'(mode), 1'($urandom_range(1)), 3, 2);
      run_frame(6, 0, 1'b0, done);
    end
  endtask

  // Widest frame: an oversized width clamps to the maximum and a zero height
  // acts as one. No idle cycles: the long stretch at full rate.
  task automatic test_widest_frame();
    bit done;
    idle_enable = 1'b0;
    set_frame(ior_pkg::MODE_CW, ior_pkg::FMT_24BIT, 300, 0);
    run_frame(MAX_DIM, 0, 1'b0, done);
    idle_enable = 1'b1;
  endtask

  // Random small frames, some with a zero dimension, some noise and some
  // aborted frames. Sometimes the next frame follows with no config.
  task automatic test_random_frames();
    int unsigned target;
    int unsigned w;
    int unsigned h;
    bit          done;
    target = good_transfers + RANDOM_OK_ITEMS;
    done   = 1'b0;
    while (good_transfers < target) begin
      if (!done || $urandom_range(3) != 0) begin
        case ($urandom_range(19))
          0:       begin w = 0; h = $urandom_range(8, 1); end
          1:       begin w = $urandom_range(8, 1); h = 0; end
          default: begin w = $urandom_range(10, 1); h = $urandom_range(10, 1); end
        endcase
        set_frame(3'($urandom_range(7)), 1'($urandom_range(1)), w, h);
      end
      run_frame(clamp_dim(pred_width_reg) * clamp_dim(pred_height_reg), 5, 1'b1, done);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = ior_pkg::REG_ORIENT;
    cfg_data       = '0;
    mismatches     = 0;
    good_transfers = 0;
    idle_enable    = 1'b1;
    pred_orient     = ior_pkg::MODE_PLAIN;
    pred_format     = ior_pkg::FMT_24BIT;
    pred_width_reg  = ior_pkg::DIM_W'(MAX_DIM);
    pred_height_reg = ior_pkg::DIM_W'(MAX_DIM);
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_special_cases();
    test_each_orientation();
    test_widest_frame();
    test_random_frames();

    // drain: every result in, then the drain margin to catch strays
    wait_idle();
    if (mismatches == 0) begin
      $display("image_orientation_rotator_core: match");
    end else begin
      $display("image_orientation_rotator_core: mismatch");
    end
    $finish;
  end

endmodule
